// ===== rtl/hcb_pkg.sv =====
// Shared types, widths and constants for the HOG cell histogram core.
// Used by every module of the block; depends on nothing else.
package hcb_pkg;

    localparam int MAG_W        = 16;
    localparam int DIRECTION_W  = 16;
    localparam int THETA_MAX_W  = 16;
    localparam int SCALE_W      = 24;
    localparam int BIN_WIDTH_W  = 16;
    localparam int BIN_MAX_W    = 4;
    localparam int BIN_INDEX_W  = 4;
    localparam int BIN_VALUE_W  = 32;
    localparam int FRAC_W       = 24;
    localparam int PROD_W       = SCALE_W + DIRECTION_W;
    localparam int HALF_Q       = 1 << (FRAC_W - 1);

    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 24;

    localparam int QUEUE_DEPTH  = 4;

    localparam int NUM_BINS_MAX_DEF = 16;
    localparam int DIR_WIDTH_DEF    = 16;

    localparam logic [THETA_MAX_W-1:0] THETA_MAX_RST       = 16'd23040;
    localparam logic [SCALE_W-1:0]     SCALE_BIN_WIDTH_RST = 24'd6554;
    localparam logic [BIN_WIDTH_W-1:0] BIN_WIDTH_RST       = 16'd2560;
    localparam logic [BIN_MAX_W-1:0]   BIN_MAX_RST         = 4'd8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_THETA_MAX       = 2'd0,
        CFG_SCALE_BIN_WIDTH = 2'd1,
        CFG_BIN_WIDTH       = 2'd2,
        CFG_BIN_MAX         = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [MAG_W-1:0]       magnitude;
        logic [DIRECTION_W-1:0] direction;
        logic                   last_pixel;
    } pixel_t;

    typedef struct packed {
        logic [BIN_INDEX_W-1:0] bin_index;
        logic [BIN_VALUE_W-1:0] bin_value;
        logic                   last_bin;
    } hist_bin_t;

    typedef struct packed {
        logic [THETA_MAX_W-1:0] theta_max;
        logic [SCALE_W-1:0]     scale_bin_width;
        logic [BIN_WIDTH_W-1:0] bin_width;
        logic [BIN_MAX_W-1:0]   bin_max;
    } cfg_t;

    typedef struct packed {
        logic [MAG_W-1:0]       magnitude;
        logic [DIRECTION_W-1:0] theta;
        logic [PROD_W-1:0]      product;
        logic                   last_pixel;
    } work_t;

    typedef struct packed {
        logic  valid;
        work_t work;
    } queue_push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_REL,
        BK_DIFF,
        BK_ABS,
        BK_MUL,
        BK_SHARE,
        BK_ADD_NEXT,
        BK_ADD_PRIM,
        BK_EMIT
    } back_state_t;

endpackage

// ===== rtl/hcb_front.sv =====
// Front end: takes pixel requests, wraps the direction and forms scale*theta.
// Two-stage pipeline feeding the work queue; depends on hcb_pkg.
module hcb_front #(
    parameter int DIR_WIDTH = hcb_pkg::DIR_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pix_valid,
    output logic                  pix_stall,
    input  hcb_pkg::pixel_t       pix_data,
    input  hcb_pkg::cfg_t         cfg,
    input  hcb_pkg::queue_status_t q_status,
    output hcb_pkg::queue_push_t  push
);
    import hcb_pkg::*;

    localparam int DIR_BITS = (DIR_WIDTH < DIRECTION_W) ? DIR_WIDTH : DIRECTION_W;
    localparam logic [DIRECTION_W-1:0] DIR_MASK =
        {DIRECTION_W{1'b1}} >> (DIRECTION_W - DIR_BITS);

    logic                   s1_valid_reg, s1_valid_next;
    logic                   s2_valid_reg, s2_valid_next;
    logic [MAG_W-1:0]       s1_mag_reg;
    logic [DIRECTION_W-1:0] s1_theta_reg;
    logic                   s1_last_reg;
    work_t                  s2_work_reg;

    logic                   s2_move, s2_free, s1_move, s1_free, accept;
    logic [DIRECTION_W-1:0] theta_masked, theta_wrapped;
    logic [PROD_W-1:0]      product;

    assign s2_move   = s2_valid_reg && !q_status.full;
    assign s2_free   = !s2_valid_reg || s2_move;
    assign s1_move   = s1_valid_reg && s2_free;
    assign s1_free   = !s1_valid_reg || s1_move;
    assign pix_stall = !s1_free;
    assign accept    = pix_valid && s1_free;

    assign theta_masked  = pix_data.direction & DIR_MASK;
    assign theta_wrapped = (theta_masked > cfg.theta_max) ?
                           theta_masked - cfg.theta_max : theta_masked;

    assign product = PROD_W'(cfg.scale_bin_width) * PROD_W'(s1_theta_reg);

    assign push.valid = s2_move;
    assign push.work  = s2_work_reg;

    always_comb
    begin
        s1_valid_next = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
        s2_valid_next = s1_move ? 1'b1 : (s2_move ? 1'b0 : s2_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mag_reg   <= pix_data.magnitude;
            s1_theta_reg <= theta_wrapped;
            s1_last_reg  <= pix_data.last_pixel;
        end
        if (s1_move)
        begin
            s2_work_reg.magnitude  <= s1_mag_reg;
            s2_work_reg.theta      <= s1_theta_reg;
            s2_work_reg.product    <= product;
            s2_work_reg.last_pixel <= s1_last_reg;
        end
    end

endmodule

// ===== rtl/hcb_queue.sv =====
// Short work queue between the front end and the accumulation sequencer.
// Register-based FIFO of work_t entries; depends on hcb_pkg.
module hcb_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  hcb_pkg::queue_push_t   push,
    input  logic                   pop,
    output hcb_pkg::queue_status_t q_status,
    output hcb_pkg::work_t         head
);
    import hcb_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    work_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;

    assign q_status.full  = (count_reg == (PTR_W + 1)'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign head           = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push.valid ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push.valid && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            entry_reg[wr_ptr_reg] <= push.work;
        end
    end

endmodule

// ===== rtl/hcb_back.sv =====
// Back end: bin selection, bilinear split, saturating accumulation and emission.
// Multi-cycle sequencer over the histogram register file; depends on hcb_pkg.
module hcb_back #(
    parameter int NUM_BINS_MAX = hcb_pkg::NUM_BINS_MAX_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  hcb_pkg::cfg_t          cfg,
    input  hcb_pkg::queue_status_t q_status,
    input  hcb_pkg::work_t         head,
    output logic                   pop,
    output logic                   hist_valid,
    input  logic                   hist_stall,
    output hcb_pkg::hist_bin_t     hist_data
);
    import hcb_pkg::*;

    localparam int BIN_IDX_W = $clog2(NUM_BINS_MAX);
    localparam int MAXB_W    = (BIN_IDX_W > BIN_MAX_W) ? BIN_IDX_W : BIN_MAX_W;
    localparam int BOFF_W    = BIN_IDX_W + BIN_WIDTH_W;
    localparam int REL_W     = DIRECTION_W + BIN_IDX_W + 1;
    localparam int DIFF_W    = REL_W + SCALE_W + 1;
    localparam int ADIFF_W   = REL_W + FRAC_W;
    localparam int PLO_W     = MAG_W + FRAC_W;
    localparam int PHI_W     = MAG_W + REL_W;
    localparam int SHARE_W   = PHI_W + 1;
    localparam int DELTA_W   = SHARE_W + 1;
    localparam int ACC_SUM_W = DELTA_W + 1;
    localparam int BRAW_W    = PROD_W - FRAC_W;

    back_state_t              state_reg, state_next;
    logic [BIN_IDX_W-1:0]     k_reg, k_next;
    logic                     out_valid_reg, out_valid_next;
    logic [BIN_VALUE_W-1:0]   hist_reg [NUM_BINS_MAX];

    work_t                    work_reg;
    logic [BIN_IDX_W-1:0]     bin_reg;
    logic signed [REL_W-1:0]  rel_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic [ADIFF_W-1:0]       adiff_reg;
    logic [BIN_IDX_W-1:0]     nxt_reg;
    logic [PLO_W-1:0]         plo_reg;
    logic [PHI_W-1:0]         phi_reg;
    logic [SHARE_W-1:0]       share_reg;
    logic signed [DELTA_W-1:0] delta_reg;
    hist_bin_t                out_data_reg;

    logic [MAXB_W-1:0]        bin_max_ext, maxb_wide;
    logic [BIN_IDX_W-1:0]     maxb;
    logic [PROD_W-1:0]        p_off;
    logic [BRAW_W-1:0]        bin_raw;
    logic [BIN_IDX_W-1:0]     bin_sat;
    logic [BOFF_W-1:0]        bin_off;
    logic signed [REL_W-1:0]  rel_calc;
    logic signed [SCALE_W:0]  scale_s;
    logic signed [DIFF_W-1:0] rel_scaled, diff_calc;
    logic [ADIFF_W-1:0]       adiff_calc;
    logic [BIN_IDX_W-1:0]     nxt_calc;
    logic [PLO_W:0]           plo_round;
    logic [SHARE_W-1:0]       share_calc;
    logic signed [DELTA_W-1:0] delta_calc;
    logic [SHARE_W:0]         next_sum;
    logic signed [ACC_SUM_W-1:0] prim_sum;
    logic [BIN_VALUE_W-1:0]   next_sat, prim_sat;

    logic                     out_load, acc_we, clear_all, emit_last;
    logic [BIN_IDX_W-1:0]     rd_addr;
    logic [BIN_VALUE_W-1:0]   rd_data, acc_value_next;

    assign bin_max_ext = MAXB_W'(cfg.bin_max);
    assign maxb_wide   = (bin_max_ext > MAXB_W'(NUM_BINS_MAX - 1)) ?
                         MAXB_W'(NUM_BINS_MAX - 1) : bin_max_ext;
    assign maxb        = maxb_wide[BIN_IDX_W-1:0];

    assign p_off   = head.product - PROD_W'(HALF_Q);
    assign bin_raw = (head.product < PROD_W'(HALF_Q)) ? '0 : p_off[PROD_W-1:FRAC_W];
    assign bin_sat = (bin_raw > BRAW_W'(maxb)) ? maxb : bin_raw[BIN_IDX_W-1:0];

    assign bin_off  = BOFF_W'(bin_reg) * BOFF_W'(cfg.bin_width);
    assign rel_calc = $signed(REL_W'(work_reg.theta)) - $signed(REL_W'(bin_off));

    assign scale_s    = $signed({1'b0, cfg.scale_bin_width});
    assign rel_scaled = rel_reg * scale_s;
    assign diff_calc  = rel_scaled - DIFF_W'(HALF_Q);

    assign adiff_calc = diff_reg[DIFF_W-1] ? ADIFF_W'(-diff_reg) : ADIFF_W'(diff_reg);

    always_comb
    begin
        if (!diff_reg[DIFF_W-1])
        begin
            nxt_calc = (bin_reg == maxb) ? '0 : bin_reg + 1'b1;
        end
        else
        begin
            nxt_calc = (bin_reg == '0) ? maxb : bin_reg - 1'b1;
        end
    end

    assign plo_round  = {1'b0, plo_reg} + (PLO_W + 1)'(HALF_Q);
    assign share_calc = SHARE_W'(phi_reg) + SHARE_W'(plo_round[PLO_W:FRAC_W]);
    assign delta_calc = $signed(DELTA_W'(work_reg.magnitude)) - $signed(DELTA_W'(share_reg));

    assign rd_data  = hist_reg[rd_addr];
    assign next_sum = (SHARE_W + 1)'(rd_data) + (SHARE_W + 1)'(share_reg);
    assign next_sat = (|next_sum[SHARE_W:BIN_VALUE_W]) ? '1 : next_sum[BIN_VALUE_W-1:0];
    assign prim_sum = $signed({{(ACC_SUM_W - BIN_VALUE_W){1'b0}}, rd_data})
                    + $signed({delta_reg[DELTA_W-1], delta_reg});

    always_comb
    begin
        if (prim_sum[ACC_SUM_W-1])
        begin
            prim_sat = '0;
        end
        else if (|prim_sum[ACC_SUM_W-2:BIN_VALUE_W])
        begin
            prim_sat = '1;
        end
        else
        begin
            prim_sat = prim_sum[BIN_VALUE_W-1:0];
        end
    end

    assign acc_value_next = (state_reg == BK_ADD_NEXT) ? next_sat : prim_sat;
    assign emit_last      = (k_reg == maxb);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    state_next = BK_REL;
                end
            end
            BK_REL:      state_next = BK_DIFF;
            BK_DIFF:     state_next = BK_ABS;
            BK_ABS:      state_next = BK_MUL;
            BK_MUL:      state_next = BK_SHARE;
            BK_SHARE:    state_next = BK_ADD_NEXT;
            BK_ADD_NEXT: state_next = BK_ADD_PRIM;
            BK_ADD_PRIM: state_next = work_reg.last_pixel ? BK_EMIT : BK_IDLE;
            BK_EMIT:
            begin
                if ((!out_valid_reg || !hist_stall) && emit_last)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:     state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        pop       = 1'b0;
        out_load  = 1'b0;
        acc_we    = 1'b0;
        clear_all = 1'b0;
        rd_addr   = k_reg;
        case (state_reg)
            BK_IDLE:
            begin
                pop = !q_status.empty;
            end
            BK_ADD_NEXT:
            begin
                rd_addr = nxt_reg;
                acc_we  = 1'b1;
            end
            BK_ADD_PRIM:
            begin
                rd_addr = bin_reg;
                acc_we  = 1'b1;
            end
            BK_EMIT:
            begin
                out_load  = !out_valid_reg || !hist_stall;
                clear_all = (!out_valid_reg || !hist_stall) && emit_last;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        k_next = k_reg;
        if (state_reg == BK_ADD_PRIM)
        begin
            k_next = '0;
        end
        else if (out_load)
        begin
            k_next = k_reg + 1'b1;
        end
        out_valid_next = out_load ? 1'b1 : (hist_stall ? out_valid_reg : 1'b0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_BINS_MAX; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
            if (clear_all)
            begin
                for (int i = 0; i < NUM_BINS_MAX; i++)
                begin
                    hist_reg[i] <= '0;
                end
            end
            else if (acc_we)
            begin
                hist_reg[rd_addr] <= acc_value_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            work_reg <= head;
            bin_reg  <= bin_sat;
        end
        if (state_reg == BK_REL)
        begin
            rel_reg <= rel_calc;
        end
        if (state_reg == BK_DIFF)
        begin
            diff_reg <= diff_calc;
        end
        if (state_reg == BK_ABS)
        begin
            adiff_reg <= adiff_calc;
            nxt_reg   <= nxt_calc;
        end
        if (state_reg == BK_MUL)
        begin
            plo_reg <= PLO_W'(work_reg.magnitude) * PLO_W'(adiff_reg[FRAC_W-1:0]);
            phi_reg <= PHI_W'(work_reg.magnitude) * PHI_W'(adiff_reg[ADIFF_W-1:FRAC_W]);
        end
        if (state_reg == BK_SHARE)
        begin
            share_reg <= share_calc;
        end
        if (state_reg == BK_ADD_NEXT)
        begin
            delta_reg <= delta_calc;
        end
        if (out_load)
        begin
            out_data_reg.bin_index <= BIN_INDEX_W'(k_reg);
            out_data_reg.bin_value <= rd_data;
            out_data_reg.last_bin  <= emit_last;
        end
    end

    assign hist_valid = out_valid_reg;
    assign hist_data  = out_data_reg;

endmodule

// ===== rtl/hog_cell_histogram_bilinear_core.sv =====
// Flow: a pixel passes the front-end registers s1 and s2 and the work queue, then the back-end
// states REL, DIFF, ABS, MUL, SHARE, ADD_NEXT and ADD_PRIM; a last pixel then enters EMIT.
// The back end pops a new pixel only from idle, once the previous one has left its sequence;
// a last pixel then emits bins 0 to min(bin_max, NUM_BINS_MAX-1), one bin per cycle while not stalled.
// The 4-entry work queue lets the front end take pixels while the back end is busy.
// Reset: configuration registers return to their defaults, the histogram and queue are cleared at once.
module hog_cell_histogram_bilinear_core #(
    parameter int NUM_BINS_MAX = hcb_pkg::NUM_BINS_MAX_DEF,
    parameter int DIR_WIDTH    = hcb_pkg::DIR_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           pix_valid,
    output logic                           pix_stall,
    input  hcb_pkg::pixel_t                pix_data,
    output logic                           hist_valid,
    input  logic                           hist_stall,
    output hcb_pkg::hist_bin_t             hist_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hcb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [hcb_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import hcb_pkg::*;

    cfg_t          cfg_reg, cfg_next;
    queue_push_t   push;
    queue_status_t q_status;
    work_t         head;
    logic          pop;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_THETA_MAX:       cfg_next.theta_max       = cfg_data[THETA_MAX_W-1:0];
                CFG_SCALE_BIN_WIDTH: cfg_next.scale_bin_width = cfg_data[SCALE_W-1:0];
                CFG_BIN_WIDTH:       cfg_next.bin_width       = cfg_data[BIN_WIDTH_W-1:0];
                CFG_BIN_MAX:         cfg_next.bin_max         = cfg_data[BIN_MAX_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.theta_max       <= THETA_MAX_RST;
            cfg_reg.scale_bin_width <= SCALE_BIN_WIDTH_RST;
            cfg_reg.bin_width       <= BIN_WIDTH_RST;
            cfg_reg.bin_max         <= BIN_MAX_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    hcb_front #(
        .DIR_WIDTH (DIR_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_data  (pix_data),
        .cfg       (cfg_reg),
        .q_status  (q_status),
        .push      (push)
    );

    hcb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .pop      (pop),
        .q_status (q_status),
        .head     (head)
    );

    hcb_back #(
        .NUM_BINS_MAX (NUM_BINS_MAX)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_status   (q_status),
        .head       (head),
        .pop        (pop),
        .hist_valid (hist_valid),
        .hist_stall (hist_stall),
        .hist_data  (hist_data)
    );

    // hold bins back to back within one histogram
    assert property (@(posedge clk) disable iff (!rst_n)
        (hist_valid && !hist_stall && !hist_data.last_bin) |=>
        (hist_valid && (hist_data.bin_index == $past(hist_data.bin_index) + 4'd1)))
        else $error("bin sequence broken inside a histogram");

    assert property (@(posedge clk) disable iff (!rst_n)
        (hist_valid && !hist_stall && hist_data.last_bin) |=> !hist_valid)
        else $error("bin presented after the final bin");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(hist_valid) |-> (hist_data.bin_index == '0))
        else $error("histogram emission does not start at bin zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push.valid && !pop) |-> !q_status.full)
        else $error("work queue overrun");

endmodule
